### design/nipd_pkg.sv
package nipd_pkg;

  // frame layout
  localparam int unsigned PosWidth = 7;
  localparam logic [PosWidth-1:0] FrameEntries = 7'd66;
  localparam int unsigned DurWidth = 16;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned HalfWidth = 16;

  // timing windows in microseconds
  localparam logic [DurWidth-1:0] LeadMarkMin  = 16'd8000;
  localparam logic [DurWidth-1:0] LeadMarkMax  = 16'd10500;
  localparam logic [DurWidth-1:0] LeadSpaceMin = 16'd4000;
  localparam logic [DurWidth-1:0] LeadSpaceMax = 16'd5000;
  localparam logic [DurWidth-1:0] BitMarkMin   = 16'd400;
  localparam logic [DurWidth-1:0] BitMarkMax   = 16'd800;
  localparam logic [DurWidth-1:0] OneSpaceLo   = 16'd1300;
  localparam logic [DurWidth-1:0] OneSpaceHi   = 16'd2000;
  localparam logic [DurWidth-1:0] ZeroSpaceLo  = 16'd350;
  localparam logic [DurWidth-1:0] ZeroSpaceHi  = 16'd800;

  // decoder state carried from one beat to the next
  typedef struct packed {
    logic [PosWidth-1:0]  pos;
    logic [WordWidth-1:0] word;
    logic                 failed;
    logic                 mark_ok;
  } state_t;

  localparam state_t StateReset = '{pos: '0, word: '0, failed: 1'b0, mark_ok: 1'b0};

  // one decoded frame result
  typedef struct packed {
    logic                 matched;
    logic [HalfWidth-1:0] address;
    logic [HalfWidth-1:0] command;
  } result_t;

endpackage

### design/nipd_if.sv
// input channel: one pulse duration per beat
interface nipd_in_if;
  import nipd_pkg::*;
  logic                valid;
  logic                ready;
  logic [DurWidth-1:0] duration;
  logic                last_entry;

  modport source (output valid, output duration, output last_entry, input ready);
  modport sink (input valid, input duration, input last_entry, output ready);
endinterface

// result channel: one decoded frame per beat
interface nipd_out_if;
  import nipd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 matched;
  logic [HalfWidth-1:0] address;
  logic [HalfWidth-1:0] command;

  modport source (output valid, output matched, output address, output command, input ready);
  modport sink (input valid, input matched, input address, input command, output ready);
endinterface

### design/nipd_step.sv
module nipd_step
  import nipd_pkg::*;
(
  input  state_t              state_i,
  input  logic [DurWidth-1:0] duration_i,
  input  logic                last_entry_i,
  output state_t              state_o,
  output result_t             result_o
);

  state_t upd;
  logic   frame_ok;

  // per-position timing checks and bit shift
  always_comb begin
    upd = state_i;
    if (state_i.pos < FrameEntries) begin
      if (state_i.pos == '0) begin
        if (duration_i < LeadMarkMin || duration_i > LeadMarkMax) upd.failed = 1'b1;
      end else if (state_i.pos == PosWidth'(1)) begin
        if (duration_i < LeadSpaceMin || duration_i > LeadSpaceMax) upd.failed = 1'b1;
      end else if (!state_i.pos[0]) begin
        upd.mark_ok = (duration_i >= BitMarkMin) && (duration_i <= BitMarkMax);
      end else begin
        upd.word = {state_i.word[WordWidth-2:0], 1'b0};
        if (!state_i.mark_ok) begin
          upd.failed = 1'b1;
        end else if (duration_i > OneSpaceLo && duration_i < OneSpaceHi) begin
          upd.word[0] = 1'b1;
        end else if (!(duration_i > ZeroSpaceLo && duration_i < ZeroSpaceHi)) begin
          upd.failed = 1'b1;
        end
      end
      upd.pos = state_i.pos + PosWidth'(1);
    end
  end

  // result on the closing beat, then back to reset
  assign frame_ok = !upd.failed && (upd.pos == FrameEntries);

  always_comb begin
    result_o.matched = frame_ok;
    result_o.address = frame_ok ? upd.word[WordWidth-1:HalfWidth] : '0;
    result_o.command = frame_ok ? upd.word[HalfWidth-1:0] : '0;
    state_o = last_entry_i ? StateReset : upd;
  end

endmodule

### design/nec_ir_pulse_decoder_core.sv
// channel  | dir | payload                      | beat when
// beat_i   | in  | duration, last_entry         | valid && ready
// res_o    | out | matched, address, command    | valid && ready
//
// one pulse per cycle while no closing pulse waits on a held result: the
// input register feeds the decode logic, which updates the frame state and, on
// the last entry, loads the result register from the registered input pulse.
// rst_ni clears frame state and both valid flags; payload is not reset.
// a closing pulse waits in the input register while a result is held
// unaccepted; other pulses keep flowing past a stalled result.
module nec_ir_pulse_decoder_core
  import nipd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  nipd_in_if.sink    beat_i,
  nipd_out_if.source res_o
);

  logic                in_valid_q;
  logic [DurWidth-1:0] duration_q;
  logic                last_q;
  state_t              state_q, state_d;
  result_t             result_d, result_q;
  logic                out_valid_q;
  logic                advance;

  // a held pulse advances unless it closes a frame into a full result slot
  assign advance = in_valid_q && (!last_q || !out_valid_q || res_o.ready);
  assign beat_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (beat_i.ready) begin
      in_valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.ready && beat_i.valid) begin
      duration_q <= beat_i.duration;
      last_q     <= beat_i.last_entry;
    end
  end

  // decode logic
  nipd_step u_step (
    .state_i      (state_q),
    .duration_i   (duration_q),
    .last_entry_i (last_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.matched = result_q.matched;
  assign res_o.address = result_q.address;
  assign res_o.command = result_q.command;

  // checks
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= FrameEntries)
    else $error("entry position beyond frame length");

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> out_valid_q)
    else $error("closing pulse gave no result");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> (state_q.pos == '0 && !state_q.failed))
    else $error("frame state not cleared after closing pulse");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(advance && last_q)) |=> !out_valid_q)
    else $error("result appeared without a closing pulse");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.matched) |-> (result_q.address == '0 && result_q.command == '0))
    else $error("unmatched result carries nonzero data");

endmodule
